[rtl/rth_pkg.sv]
// Package with field widths, shared constants and types of the RGB to HSV converter.
package rth_pkg;

   localparam int CHAN_W = 8;
   localparam int HUE_W  = 15;
   localparam int SAT_W  = 13;
   localparam int BRI_W  = 8;

   // Divisors are twice chroma or twice value, so they need one bit more than a channel.
   localparam int DIV_W  = CHAN_W + 1;

   // Scaled sector difference plus sector offset, at most six times chroma.
   localparam int X_W    = 11;

   localparam int SECTOR_DEG    = 60;
   localparam int FULL_TURN_DEG = 360;

   typedef struct packed {
      logic              gray;
      logic [BRI_W-1:0]  bright;
   } side_type;

endpackage

[rtl/rth_if.sv]
// Valid/ready channel interfaces for the pixel input and the HSV result.
interface rth_req_if;
   logic                           valid;
   logic                           ready;
   logic [rth_pkg::CHAN_W-1:0]     red;
   logic [rth_pkg::CHAN_W-1:0]     green;
   logic [rth_pkg::CHAN_W-1:0]     blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rth_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [rth_pkg::HUE_W-1:0]      hue;
   logic [rth_pkg::SAT_W-1:0]      saturation;
   logic [rth_pkg::BRI_W-1:0]      brightness;

   modport source (output valid, output hue, output saturation, output brightness, input ready);
   modport sink   (input valid, input hue, input saturation, input brightness, output ready);
endinterface

[rtl/rth_front.sv]
// Front stages: input register, max/min and sector select, numerator and divisor forming.
module rth_front #(
   parameter int HFB = 6,
   parameter int SFB = 12,
   parameter int QW  = 15
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [rth_pkg::CHAN_W-1:0]    red,
   input  logic [rth_pkg::CHAN_W-1:0]    green,
   input  logic [rth_pkg::CHAN_W-1:0]    blue,
   output logic                          out_valid,
   input  logic                          out_ready,
   output rth_pkg::side_type             out_side,
   output logic [rth_pkg::DIV_W-1:0]     out_rem_h,
   output logic [QW-1:0]                 out_work_h,
   output logic [rth_pkg::DIV_W-1:0]     out_dsr_h,
   output logic [rth_pkg::DIV_W-1:0]     out_rem_s,
   output logic [QW-1:0]                 out_work_s,
   output logic [rth_pkg::DIV_W-1:0]     out_dsr_s
);

   localparam int NW = QW + rth_pkg::DIV_W;
   localparam logic [NW-1:0] HUE_MUL = NW'(2 * rth_pkg::SECTOR_DEG * (2 ** HFB));

   localparam int CW = rth_pkg::CHAN_W;
   localparam int XW = rth_pkg::X_W;

   logic             v0_ff, v1_ff, v2_ff;
   logic             rdy0, rdy1, rdy2;

   logic [CW-1:0]    r0_ff, g0_ff, b0_ff;

   logic [CW-1:0]    hi_in, lo_in, c_in;
   logic [XW-1:0]    x_in, c2, c4, c6;
   logic [CW-1:0]    hi1_ff, c1_ff;
   logic [XW-1:0]    x1_ff;

   logic [NW-1:0]    nh_in, ns_in;
   rth_pkg::side_type side_ff;
   logic [rth_pkg::DIV_W-1:0] rem_h_ff, dsr_h_ff, rem_s_ff, dsr_s_ff;
   logic [QW-1:0]    work_h_ff, work_s_ff;

   assign rdy2     = !v2_ff || out_ready;
   assign rdy1     = !v1_ff || rdy2;
   assign rdy0     = !v0_ff || rdy1;
   assign in_ready = rdy0;

   // Largest, smallest and the scaled difference of the winning sector.
   always_comb begin
      hi_in = r0_ff;
      lo_in = r0_ff;
      if (g0_ff > hi_in) hi_in = g0_ff;
      if (b0_ff > hi_in) hi_in = b0_ff;
      if (g0_ff < lo_in) lo_in = g0_ff;
      if (b0_ff < lo_in) lo_in = b0_ff;
      c_in = hi_in - lo_in;
      c2   = XW'(c_in) << 1;
      c4   = XW'(c_in) << 2;
      c6   = c4 + c2;
      if (r0_ff == hi_in) begin
         if (g0_ff >= b0_ff) begin
            x_in = XW'(g0_ff) - XW'(b0_ff);
         end else begin
            x_in = XW'(g0_ff) + c6 - XW'(b0_ff);
         end
      end else if (g0_ff == hi_in) begin
         x_in = XW'(b0_ff) + c2 - XW'(r0_ff);
      end else begin
         x_in = XW'(r0_ff) + c4 - XW'(g0_ff);
      end
   end

   // Rounded quotients are floor((2n + d) / 2d), so the dividends carry the half divisor.
   always_comb begin
      nh_in = NW'(x1_ff) * HUE_MUL + NW'(c1_ff);
      ns_in = (NW'(c1_ff) << (SFB + 1)) + NW'(hi1_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (rdy0) v0_ff <= in_valid;
         if (rdy1) v1_ff <= v0_ff;
         if (rdy2) v2_ff <= v1_ff;
      end
      if (rdy0) begin
         r0_ff <= red;
         g0_ff <= green;
         b0_ff <= blue;
      end
      if (rdy1) begin
         hi1_ff <= hi_in;
         c1_ff  <= c_in;
         x1_ff  <= x_in;
      end
      if (rdy2) begin
         side_ff.gray   <= (c1_ff == '0);
         side_ff.bright <= hi1_ff;
         rem_h_ff       <= nh_in[NW-1:QW];
         work_h_ff      <= nh_in[QW-1:0];
         dsr_h_ff       <= {c1_ff, 1'b0};
         rem_s_ff       <= ns_in[NW-1:QW];
         work_s_ff      <= ns_in[QW-1:0];
         dsr_s_ff       <= {hi1_ff, 1'b0};
      end
   end

   assign out_valid  = v2_ff;
   assign out_side   = side_ff;
   assign out_rem_h  = rem_h_ff;
   assign out_work_h = work_h_ff;
   assign out_dsr_h  = dsr_h_ff;
   assign out_rem_s  = rem_s_ff;
   assign out_work_s = work_s_ff;
   assign out_dsr_s  = dsr_s_ff;

endmodule

[rtl/rth_div_step.sv]
// One restoring-division stage that retires one quotient bit of the hue and saturation lanes.
module rth_div_step #(
   parameter int QW = 15
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  rth_pkg::side_type             in_side,
   input  logic [rth_pkg::DIV_W-1:0]     in_rem_h,
   input  logic [QW-1:0]                 in_work_h,
   input  logic [rth_pkg::DIV_W-1:0]     in_dsr_h,
   input  logic [rth_pkg::DIV_W-1:0]     in_rem_s,
   input  logic [QW-1:0]                 in_work_s,
   input  logic [rth_pkg::DIV_W-1:0]     in_dsr_s,
   output logic                          out_valid,
   input  logic                          out_ready,
   output rth_pkg::side_type             out_side,
   output logic [rth_pkg::DIV_W-1:0]     out_rem_h,
   output logic [QW-1:0]                 out_work_h,
   output logic [rth_pkg::DIV_W-1:0]     out_dsr_h,
   output logic [rth_pkg::DIV_W-1:0]     out_rem_s,
   output logic [QW-1:0]                 out_work_s,
   output logic [rth_pkg::DIV_W-1:0]     out_dsr_s
);

   localparam int DW = rth_pkg::DIV_W;

   logic              valid_ff;
   rth_pkg::side_type side_ff;
   logic [DW-1:0]     rem_h_ff, dsr_h_ff, rem_s_ff, dsr_s_ff;
   logic [QW-1:0]     work_h_ff, work_s_ff;

   logic [DW:0]       t_h, t_s, d_h, d_s;
   logic              ge_h, ge_s;
   logic [DW-1:0]     rem_h_in, rem_s_in;

   assign in_ready = !valid_ff || out_ready;

   // While the divisor is nonzero the partial remainder stays below it, so one compare and subtract fits.
   always_comb begin
      t_h      = {in_rem_h, in_work_h[QW-1]};
      d_h      = {1'b0, in_dsr_h};
      ge_h     = (t_h >= d_h);
      rem_h_in = ge_h ? DW'(t_h - d_h) : t_h[DW-1:0];
      t_s      = {in_rem_s, in_work_s[QW-1]};
      d_s      = {1'b0, in_dsr_s};
      ge_s     = (t_s >= d_s);
      rem_s_in = ge_s ? DW'(t_s - d_s) : t_s[DW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready) begin
         side_ff   <= in_side;
         rem_h_ff  <= rem_h_in;
         work_h_ff <= {in_work_h[QW-2:0], ge_h};
         dsr_h_ff  <= in_dsr_h;
         rem_s_ff  <= rem_s_in;
         work_s_ff <= {in_work_s[QW-2:0], ge_s};
         dsr_s_ff  <= in_dsr_s;
      end
   end

   assign out_valid  = valid_ff;
   assign out_side   = side_ff;
   assign out_rem_h  = rem_h_ff;
   assign out_work_h = work_h_ff;
   assign out_dsr_h  = dsr_h_ff;
   assign out_rem_s  = rem_s_ff;
   assign out_work_s = work_s_ff;
   assign out_dsr_s  = dsr_s_ff;

endmodule

[rtl/rgb_to_hsv.sv]
// Top level of the pipelined RGB to HSV pixel converter.
//
//   Channel   Direction  Beat contents
//   req_bus   in         red, green, blue (8 bits each)
//   rsp_bus   out        hue (15), saturation (13), brightness (8)
//
// One pixel enters per clock and one result leaves per clock when the sink keeps up.
// The path is three front stages and then one divider stage per quotient bit, QW divider
// stages in all, where QW is the wider of the hue and saturation quotients.
// Reset is synchronous and active high and empties every stage; payload is not cleared.
// Each stage loads whenever it is empty or its successor moves, so a stall on rsp_bus
// fills the bubbles behind it and then holds every beat in place, none lost or repeated.
module rgb_to_hsv #(
   parameter int HUE_FRAC_BITS = 6,
   parameter int SAT_FRAC_BITS = 12
) (
   input  logic       clock,
   input  logic       reset,
   rth_req_if.sink    req_bus,
   rth_rsp_if.source  rsp_bus
);

   // Hue quotient is below 360 degrees in hue units, plus one for rounding up to the turn.
   localparam int HUE_MAX = rth_pkg::FULL_TURN_DEG * (2 ** HUE_FRAC_BITS);
   localparam int HQW     = $clog2(HUE_MAX + 1);
   // Saturation quotient reaches exactly 1.0 when the smallest channel is zero.
   localparam int SQW     = SAT_FRAC_BITS + 1;
   localparam int QW      = (HQW > SQW) ? HQW : SQW;
   localparam int DW      = rth_pkg::DIV_W;

   localparam bit HUE_FITS = (HUE_MAX <= (2 ** rth_pkg::HUE_W));
   localparam bit SAT_FITS = (SQW <= rth_pkg::SAT_W);
   localparam int SAT_ONE  = 2 ** SAT_FRAC_BITS;

   // Stage k of the divider reads slot k and writes slot k + 1; slot 0 is the front end.
   logic              valid [0:QW];
   logic              ready [0:QW];
   rth_pkg::side_type side  [0:QW];
   logic [DW-1:0]     rem_h [0:QW];
   logic [DW-1:0]     dsr_h [0:QW];
   logic [DW-1:0]     rem_s [0:QW];
   logic [DW-1:0]     dsr_s [0:QW];
   logic [QW-1:0]     work_h [0:QW];
   logic [QW-1:0]     work_s [0:QW];

   rth_front #(
      .HFB (HUE_FRAC_BITS),
      .SFB (SAT_FRAC_BITS),
      .QW  (QW)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_bus.valid),
      .in_ready   (req_bus.ready),
      .red        (req_bus.red),
      .green      (req_bus.green),
      .blue       (req_bus.blue),
      .out_valid  (valid[0]),
      .out_ready  (ready[0]),
      .out_side   (side[0]),
      .out_rem_h  (rem_h[0]),
      .out_work_h (work_h[0]),
      .out_dsr_h  (dsr_h[0]),
      .out_rem_s  (rem_s[0]),
      .out_work_s (work_s[0]),
      .out_dsr_s  (dsr_s[0])
   );

   // After QW steps the work registers hold the rounded quotients.
   for (genvar k = 0; k < QW; k++) begin : g_div
      rth_div_step #(
         .QW (QW)
      ) u_step (
         .clock      (clock),
         .reset      (reset),
         .in_valid   (valid[k]),
         .in_ready   (ready[k]),
         .in_side    (side[k]),
         .in_rem_h   (rem_h[k]),
         .in_work_h  (work_h[k]),
         .in_dsr_h   (dsr_h[k]),
         .in_rem_s   (rem_s[k]),
         .in_work_s  (work_s[k]),
         .in_dsr_s   (dsr_s[k]),
         .out_valid  (valid[k+1]),
         .out_ready  (ready[k+1]),
         .out_side   (side[k+1]),
         .out_rem_h  (rem_h[k+1]),
         .out_work_h (work_h[k+1]),
         .out_dsr_h  (dsr_h[k+1]),
         .out_rem_s  (rem_s[k+1]),
         .out_work_s (work_s[k+1]),
         .out_dsr_s  (dsr_s[k+1])
      );
   end

   assign ready[QW] = rsp_bus.ready;
   assign rsp_bus.valid = valid[QW];

   // A gray pixel divides by zero chroma and a black one by zero value; both quotients
   // are garbage then and are forced to zero. The remainders of the last stage go unused
   // as results but still check the divider below.
   assign rsp_bus.hue        = side[QW].gray ? '0 : rth_pkg::HUE_W'(work_h[QW]);
   assign rsp_bus.saturation = (side[QW].bright == '0) ? '0
                                                       : rth_pkg::SAT_W'(work_s[QW]);
   assign rsp_bus.brightness = side[QW].bright;

`ifndef SYNTHESIS
   // A black pixel has neither hue nor saturation.
   a_black: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.brightness == '0)
         |-> (rsp_bus.saturation == '0 && rsp_bus.hue == '0))
      else $error("black pixel gave nonzero hue or saturation");

   // Any chroma of one or more gives a nonzero saturation, so zero saturation means gray.
   // This only holds while the saturation quotient fits its field without wrapping.
   a_gray: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && SAT_FITS && rsp_bus.saturation == '0) |-> (rsp_bus.hue == '0))
      else $error("zero saturation with nonzero hue");

   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && HUE_FITS) |-> (32'(rsp_bus.hue) < HUE_MAX))
      else $error("hue reached a full turn");

   a_sat_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && SAT_FITS) |-> (32'(rsp_bus.saturation) <= SAT_ONE))
      else $error("saturation above one");

   // For a colored pixel the hue remainder must end below its divisor.
   a_rem: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !side[QW].gray) |-> (rem_h[QW] < dsr_h[QW]))
      else $error("hue divider remainder out of range");

   // Likewise the saturation remainder for any pixel that is not black.
   a_rem_s: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && side[QW].bright != '0) |-> (rem_s[QW] < dsr_s[QW]))
      else $error("saturation divider remainder out of range");
`endif

endmodule

[test/rth_checker.sv]
// Checker that predicts the HSV result of every accepted pixel and compares the returned beats.
`timescale 1ns / 1ps

module rth_checker #(
   parameter int HUE_FRAC_BITS = 6,
   parameter int SAT_FRAC_BITS = 12
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic [rth_pkg::CHAN_W-1:0] req_red,
   input  logic [rth_pkg::CHAN_W-1:0] req_green,
   input  logic [rth_pkg::CHAN_W-1:0] req_blue,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic [rth_pkg::HUE_W-1:0]  rsp_hue,
   input  logic [rth_pkg::SAT_W-1:0]  rsp_saturation,
   input  logic [rth_pkg::BRI_W-1:0]  rsp_brightness,
   output int                         mismatch_count,
   output int                         pending_count
);

   localparam int MAX_REPORTS   = 10;
   localparam int GREEN_SECTOR  = 2;
   localparam int BLUE_SECTOR   = 4;

   typedef struct packed {
      logic [rth_pkg::CHAN_W-1:0] red;
      logic [rth_pkg::CHAN_W-1:0] green;
      logic [rth_pkg::CHAN_W-1:0] blue;
      logic [rth_pkg::HUE_W-1:0]  hue;
      logic [rth_pkg::SAT_W-1:0]  saturation;
      logic [rth_pkg::BRI_W-1:0]  brightness;
   } hsv_pixel_type;

   hsv_pixel_type expected_hsv_q[$];
   int            wrong_results = 0;
   int            queued_pixels = 0;

   assign mismatch_count = wrong_results;
   assign pending_count  = queued_pixels;

   // Exact hue and saturation, each rounded to nearest with ties upward.
   function automatic hsv_pixel_type convert_pixel(input logic [rth_pkg::CHAN_W-1:0] red,
                                                   input logic [rth_pkg::CHAN_W-1:0] green,
                                                   input logic [rth_pkg::CHAN_W-1:0] blue);
      longint        r;
      longint        g;
      longint        b;
      longint        top;
      longint        bottom;
      longint        chroma;
      longint        scale;
      longint        numer;
      longint        hue_full;
      longint        sat_full;
      hsv_pixel_type pix;
      r = longint'(red);
      g = longint'(green);
      b = longint'(blue);
      scale = longint'(1) << HUE_FRAC_BITS;
      top = r;
      bottom = r;
      if (g > top) top = g;
      if (b > top) top = b;
      if (g < bottom) bottom = g;
      if (b < bottom) bottom = b;
      chroma = top - bottom;
      hue_full = 0;
      sat_full = 0;
      if (chroma != 0) begin
         if (top == r) begin
            numer = rth_pkg::SECTOR_DEG * scale * (g - b);
            if (numer < 0) numer += rth_pkg::FULL_TURN_DEG * scale * chroma;
         end else if (top == g) begin
            numer = rth_pkg::SECTOR_DEG * scale * (b - r + GREEN_SECTOR * chroma);
         end else begin
            numer = rth_pkg::SECTOR_DEG * scale * (r - g + BLUE_SECTOR * chroma);
         end
         hue_full = (2 * numer + chroma) / (2 * chroma);
      end
      if (top != 0) sat_full = (2 * (chroma << SAT_FRAC_BITS) + top) / (2 * top);
      pix.red        = red;
      pix.green      = green;
      pix.blue       = blue;
      pix.hue        = hue_full[rth_pkg::HUE_W-1:0];
      pix.saturation = sat_full[rth_pkg::SAT_W-1:0];
      pix.brightness = top[rth_pkg::BRI_W-1:0];
      return pix;
   endfunction

   always @(posedge clock) begin
      hsv_pixel_type want;
      if (reset) begin
         expected_hsv_q.delete();
         queued_pixels <= 0;
      end else begin
         // Retire first, so a result cannot match a pixel accepted on the same edge.
         if (rsp_valid && rsp_ready) begin
            if (expected_hsv_q.size() == 0) begin
               if (wrong_results < MAX_REPORTS)
                  $display("%0t: result beat with no pixel outstanding: hue %0d sat %0d val %0d",
                           $realtime, rsp_hue, rsp_saturation, rsp_brightness);
               wrong_results++;
            end else begin
               want = expected_hsv_q.pop_front();
               if (rsp_hue !== want.hue || rsp_saturation !== want.saturation ||
                   rsp_brightness !== want.brightness) begin
                  if (wrong_results < MAX_REPORTS)
                     $display({"%0t: pixel (%0d,%0d,%0d) expected hue %0d sat %0d val %0d,",
                               " got %0d %0d %0d"},
                              $realtime, want.red, want.green, want.blue,
                              want.hue, want.saturation, want.brightness,
                              rsp_hue, rsp_saturation, rsp_brightness);
                  wrong_results++;
               end
            end
         end
         if (req_valid && req_ready)
            expected_hsv_q.push_back(convert_pixel(req_red, req_green, req_blue));
         queued_pixels <= expected_hsv_q.size();
      end
   end

endmodule

[test/tb_top.sv]
// Testbench top that drives pixels into the RGB to HSV converter and gives the verdict.
`timescale 1ns / 1ps

module tb_top;

   localparam int HUE_FRAC_BITS = 6;
   localparam int SAT_FRAC_BITS = 12;
   localparam int RANDOM_PIXELS = 1000;
   // Margin to wait after the last result is back, before the verdict is given.
   localparam int DRAIN_CYCLES  = 40;
   // Longest quiet stretch a correct run can show is a sender gap plus the pipeline
   // latency plus the longest receiver stall.
   localparam int IDLE_LIMIT    = 2000;

   logic clock = 1'b0;
   logic reset;

   // Number of beats left before the sender takes its next gap.
   int burst_left = 0;
   int idle_cycles = 0;
   int mismatch_count;
   int pending_count;

   rth_req_if req_bus ();
   rth_rsp_if rsp_bus ();

   rgb_to_hsv #(
      .HUE_FRAC_BITS(HUE_FRAC_BITS),
      .SAT_FRAC_BITS(SAT_FRAC_BITS)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // The checker sees both channels as they are at each rising edge and keeps its
   // own queue of predicted results; the top only reads back two counters.
   rth_checker #(
      .HUE_FRAC_BITS(HUE_FRAC_BITS),
      .SAT_FRAC_BITS(SAT_FRAC_BITS)
   ) hsv_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_bus.valid),
      .req_ready      (req_bus.ready),
      .req_red        (req_bus.red),
      .req_green      (req_bus.green),
      .req_blue       (req_bus.blue),
      .rsp_valid      (rsp_bus.valid),
      .rsp_ready      (rsp_bus.ready),
      .rsp_hue        (rsp_bus.hue),
      .rsp_saturation (rsp_bus.saturation),
      .rsp_brightness (rsp_bus.brightness),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   always #5 clock = ~clock;

   // Presents one pixel and holds it until the converter takes it. Bursts of random
   // length are separated by random gaps; an empty gap lets two bursts run
   // together, and now and then a long gap lets the pipeline run dry.
   task automatic send_pixel(input logic [rth_pkg::CHAN_W-1:0] red,
                             input logic [rth_pkg::CHAN_W-1:0] green,
                             input logic [rth_pkg::CHAN_W-1:0] blue);
      int gap;
      if (burst_left == 0) begin
         if ($urandom_range(0, 7) == 0) gap = $urandom_range(10, 40);
         else gap = $urandom_range(0, 4);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      req_bus.valid <= 1'b1;
      req_bus.red   <= red;
      req_bus.green <= green;
      req_bus.blue  <= blue;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      burst_left--;
   endtask

   // Stops sending and waits until every predicted result has come back.
   task automatic wait_for_results();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // Picks a channel value close to one rail or the other.
   function automatic logic [rth_pkg::CHAN_W-1:0] rail_value();
      logic [rth_pkg::CHAN_W-1:0] v;
      if ($urandom_range(0, 1) == 1) v = 8'($urandom_range(253, 255));
      else v = 8'($urandom_range(0, 2));
      return v;
   endfunction

   // One random pixel, with the mix weighted toward the corners of the conversion:
   // channel ties that pick the sector, gray levels, tiny chroma and values at the rails.
   task automatic send_random_pixel();
      logic [rth_pkg::CHAN_W-1:0] r;
      logic [rth_pkg::CHAN_W-1:0] g;
      logic [rth_pkg::CHAN_W-1:0] b;
      logic [rth_pkg::CHAN_W-1:0] shade;
      int                         kind;
      r = 8'($urandom());
      g = 8'($urandom());
      b = 8'($urandom());
      kind = $urandom_range(0, 9);
      case (kind)
         5: begin
            // Two channels share the largest value.
            shade = ($urandom_range(0, 1) == 1) ? r : 8'd255;
            case ($urandom_range(0, 2))
               0: begin r = shade; g = shade; b = 8'(b % (shade + 1)); end
               1: begin r = shade; b = shade; g = 8'(g % (shade + 1)); end
               default: begin g = shade; b = shade; r = 8'(r % (shade + 1)); end
            endcase
         end
         6: begin
            g = r;
            b = r;
         end
         7: begin
            r = 8'($urandom_range(0, 3));
            g = 8'($urandom_range(0, 3));
            b = 8'($urandom_range(0, 3));
         end
         8: begin
            // Channels near the rails: chroma near its largest or near zero.
            r = rail_value();
            g = rail_value();
            b = rail_value();
         end
         9: begin
            // Chroma of one, where the hue quotient has the coarsest rounding.
            g = r;
            b = (r == 8'd255) ? 8'd254 : r + 8'd1;
         end
         default: begin
         end
      endcase
      send_pixel(r, g, b);
   endtask

   // The receiver picks its stall mode afresh at regular intervals: always ready, random stalls,
   // alternate cycles, or long stalls with only a rare ready.
   initial begin
      int stall_mode;
      int stall_tick;
      stall_mode = 0;
      stall_tick = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_tick % 64 == 0) stall_mode = $urandom_range(0, 3);
         case (stall_mode)
            0: rsp_bus.ready <= 1'b1;
            1: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
            2: rsp_bus.ready <= stall_tick[0];
            default: rsp_bus.ready <= (stall_tick % 8 == 0);
         endcase
         stall_tick++;
      end
   end

   // A run that stops moving beats is stuck; count the quiet cycles and give up.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   initial begin
      reset         <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.red   <= '0;
      req_bus.green <= '0;
      req_bus.blue  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed pixels. Black and white cover every input bit at both values, and
      // black also checks that a zero value gives zero saturation.
      send_pixel(8'd0,   8'd0,   8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd128, 8'd128, 8'd128);
      // Primaries, one per sector.
      send_pixel(8'd255, 8'd0,   8'd0);
      send_pixel(8'd0,   8'd255, 8'd0);
      send_pixel(8'd0,   8'd0,   8'd255);
      // Ties for the largest channel: red wins over green and blue, green over blue.
      send_pixel(8'd255, 8'd255, 8'd0);
      send_pixel(8'd255, 8'd0,   8'd255);
      send_pixel(8'd0,   8'd255, 8'd255);
      send_pixel(8'd100, 8'd100, 8'd40);
      send_pixel(8'd90,  8'd20,  8'd90);
      send_pixel(8'd10,  8'd77,  8'd77);
      // Red sector with blue above green, where the hue wraps below 360 degrees.
      send_pixel(8'd255, 8'd0,   8'd1);
      send_pixel(8'd255, 8'd0,   8'd254);
      send_pixel(8'd200, 8'd50,  8'd51);
      // Smallest nonzero pixels and a chroma of one.
      send_pixel(8'd1,   8'd0,   8'd0);
      send_pixel(8'd0,   8'd1,   8'd0);
      send_pixel(8'd0,   8'd0,   8'd1);
      send_pixel(8'd1,   8'd0,   8'd1);
      send_pixel(8'd255, 8'd254, 8'd254);
      // Near the sector borders and a dim pixel with a chroma of one.
      send_pixel(8'd255, 8'd254, 8'd0);
      send_pixel(8'd254, 8'd255, 8'd0);
      send_pixel(8'd0,   8'd254, 8'd255);
      send_pixel(8'd3,   8'd2,   8'd2);

      // Let the pipeline run dry once before the random part.
      wait_for_results();

      for (int i = 0; i < RANDOM_PIXELS; i++) begin
         if (i == RANDOM_PIXELS / 2) wait_for_results();
         send_random_pixel();
      end

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && pending_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
